### design/chacha20_keystream_cipher_core_assert.svh
// assertion macros shared by the cck_seq and top-level cipher core rtl files
// each macro expects clk and rst in the scope where it is used
`ifndef CHACHA20_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`define CHACHA20_KEYSTREAM_CIPHER_CORE_ASSERT_SVH

// condition must never hold outside reset
`define CCK_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("cck assertion failed");

// antecedent implies consequent in the same cycle
`define CCK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cck assertion failed");

// antecedent implies consequent in the next cycle
`define CCK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cck assertion failed");

`endif

### design/cck_pkg.sv
// shared types, constants and the microcode rom of the chacha20 keystream core
// no dependencies
`default_nettype none

package cck_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] blk_t;

  // block constant words
  localparam word_t SIGMA0     = 32'h61707865;
  localparam word_t SIGMA1_LNG = 32'h3320646e;
  localparam word_t SIGMA1_SHT = 32'h3120646e;
  localparam word_t SIGMA2_LNG = 32'h79622d32;
  localparam word_t SIGMA2_SHT = 32'h79622d36;
  localparam word_t SIGMA3     = 32'h6b206574;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LOW   = 3'd0;
  localparam logic [2:0] REG_KEY_MID   = 3'd1;
  localparam logic [2:0] REG_KEY_UPPER = 3'd2;
  localparam logic [2:0] REG_KEY_TOP   = 3'd3;
  localparam logic [2:0] REG_NONCE_LO  = 3'd4;
  localparam logic [2:0] REG_NONCE_HI  = 3'd5;
  localparam logic [2:0] REG_START_CTR = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  // bytes in one keystream block
  localparam logic [6:0] BLK_BYTES = 7'd64;

  typedef enum logic [1:0] {OP_NONE, OP_AB, OP_CD} op_t;
  typedef enum logic [1:0] {ROT16, ROT12, ROT8, ROT7} rot_t;
  typedef enum logic [1:0] {PERM_NONE, PERM_DIAG, PERM_UNDIAG} perm_t;

  // one control word of the block program
  typedef struct packed {
    logic       load;
    op_t        op;
    rot_t       rot;
    perm_t      perm;
    logic       loop;
    logic       fin;
    logic [1:0] row;
    logic       last;
  } ctl_t;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] PROG_LEN   = 4'd13;
  localparam logic [STEP_W-1:0] LOOP_START = 4'd1;

  localparam ctl_t CTL_NOP = '{load: 1'b0, op: OP_NONE, rot: ROT16, perm: PERM_NONE,
                               loop: 1'b0, fin: 1'b0, row: 2'd0, last: 1'b0};

  // rotate left by the selected amount
  function automatic word_t rotl(input word_t v, input rot_t r);
    word_t res;
    case (r)
      ROT16:   res = {v[15:0], v[31:16]};
      ROT12:   res = {v[19:0], v[31:20]};
      ROT8:    res = {v[23:0], v[31:24]};
      ROT7:    res = {v[24:0], v[31:25]};
      default: res = v;
    endcase
    return res;
  endfunction

  // block program: load, column round and diagonal round (looped together), final add by row
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = CTL_NOP;
    case (step)
      4'd0: begin
        w.load = 1'b1;
      end
      4'd1: begin
        w.op = OP_AB; w.rot = ROT16;
      end
      4'd2: begin
        w.op = OP_CD; w.rot = ROT12;
      end
      4'd3: begin
        w.op = OP_AB; w.rot = ROT8;
      end
      4'd4: begin
        w.op = OP_CD; w.rot = ROT7; w.perm = PERM_DIAG;
      end
      4'd5: begin
        w.op = OP_AB; w.rot = ROT16;
      end
      4'd6: begin
        w.op = OP_CD; w.rot = ROT12;
      end
      4'd7: begin
        w.op = OP_AB; w.rot = ROT8;
      end
      4'd8: begin
        w.op = OP_CD; w.rot = ROT7; w.perm = PERM_UNDIAG; w.loop = 1'b1;
      end
      4'd9: begin
        w.fin = 1'b1; w.row = 2'd0;
      end
      4'd10: begin
        w.fin = 1'b1; w.row = 2'd1;
      end
      4'd11: begin
        w.fin = 1'b1; w.row = 2'd2;
      end
      4'd12: begin
        w.fin = 1'b1; w.row = 2'd3; w.last = 1'b1;
      end
      default: w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/cck_seq.sv
// microcode sequencer: step counter, double-round counter and rom readout
// depends on cck_pkg and the assertion macro header
`default_nettype none
`include "chacha20_keystream_cipher_core_assert.svh"

module cck_seq #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output cck_pkg::ctl_t      ctl,
  output logic               busy
);

  localparam int RND_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

  logic [cck_pkg::STEP_W-1:0] step;
  logic [RND_W-1:0]           rnd;
  cck_pkg::ctl_t              word;

  // rom readout, quiet while idle
  assign word = cck_pkg::ucode(step);
  assign ctl  = busy ? word : cck_pkg::CTL_NOP;

  // step and round counting with the loop jump
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      rnd  <= '0;
    end else if (busy) begin
      if (word.last) begin
        busy <= 1'b0;
        step <= '0;
      end else if (word.loop && (rnd != RND_LAST)) begin
        rnd  <= rnd + 1'b1;
        step <= cck_pkg::LOOP_START;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  `CCK_NEVER(a_seq_start_busy, start && busy)
  `CCK_IMPL(a_seq_last_rounds, busy && word.last, rnd == RND_LAST)
  `CCK_IMPL(a_seq_step_range, busy, step < cck_pkg::PROG_LEN)

endmodule

`default_nettype wire

### design/cck_lanes.sv
// datapath: 16-word working block with four quarter-round lanes, one
// add-xor-rotate per lane per step, row permutes for the diagonal round
// depends on cck_pkg
`default_nettype none

module cck_lanes (
  input  wire logic           clk,
  input  wire cck_pkg::ctl_t  ctl,
  input  wire cck_pkg::blk_t  init,
  output cck_pkg::blk_t       blk
);

  cck_pkg::blk_t x;
  cck_pkg::blk_t y;
  cck_pkg::blk_t z;

  // lane arithmetic on the four columns
  always_comb begin
    y = x;
    for (int c = 0; c < 4; c++) begin
      case (ctl.op)
        cck_pkg::OP_AB: begin
          y[c]      = x[c] + x[4+c];
          y[12+c]   = cck_pkg::rotl(x[12+c] ^ y[c], ctl.rot);
        end
        cck_pkg::OP_CD: begin
          y[8+c]    = x[8+c] + x[12+c];
          y[4+c]    = cck_pkg::rotl(x[4+c] ^ y[8+c], ctl.rot);
        end
        default: ;
      endcase
    end
  end

  // row permute, load and final add
  always_comb begin
    z = y;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (ctl.perm)
          cck_pkg::PERM_DIAG:   z[4*r+c] = y[4*r+((c+r)&3)];
          cck_pkg::PERM_UNDIAG: z[4*r+c] = y[4*r+((c-r+4)&3)];
          default: ;
        endcase
      end
    end
    if (ctl.load) begin
      z = init;
    end
    if (ctl.fin) begin
      for (int c = 0; c < 4; c++) begin
        z[{ctl.row, 2'(c)}] = x[{ctl.row, 2'(c)}] + init[{ctl.row, 2'(c)}];
      end
    end
  end

  always_ff @(posedge clk) begin
    x <= z;
  end

  assign blk = x;

endmodule

`default_nettype wire

### design/chacha20_keystream_cipher_core.sv
// ChaCha20 byte-stream cipher: config registers, counter words, byte buffer
// control and result queue; depends on cck_pkg, cck_seq, cck_lanes, macro header
//
// usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the key,
//    nonce, start counter and mode registers; cfg_ready is always high
//  - slave stream: s_tuser = 1 restarts the stream from config (no result),
//    s_tuser = 0 sends a data byte in s_tdata, answered by one output beat
//  - master stream: m_tdata carries the input byte XOR keystream byte
//  - a byte from the buffered block is XORed and written into the output queue
//  - an empty buffer first runs the block program of 8*DOUBLE_ROUNDS+5
//    sequencer steps (85 for 20 rounds), then answers
//  - the block rate is set by the four quarter-round lanes doing one
//    add-xor-rotate per step
//  - a two-beat output queue lets a byte be taken while a result waits;
//    s_tready drops while a block is made or the queue is full
//  - reset clears the counter words and buffer, mode resets to a 32-byte
//    key with an 8-byte nonce, all other registers to zero
`default_nettype none
`include "chacha20_keystream_cipher_core_assert.svh"

module chacha20_keystream_cipher_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_in
  input  wire logic        s_tuser,    // [0] func
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata     // [7:0] data_out
);

  // config registers
  logic [63:0] key_words_low;
  logic [63:0] key_words_mid;
  logic [63:0] key_words_upper;
  logic [63:0] key_words_top;
  logic [63:0] nonce_first;
  logic [31:0] nonce_last;
  logic [63:0] start_counter;
  logic [1:0]  mode;

  // stream state
  logic [127:0] counter_words;
  logic [6:0]   bytes_left;
  logic         gen_pending;
  logic [7:0]   pend_data;
  logic         skid_valid;
  logic [7:0]   skid_data;

  cck_pkg::ctl_t ctl;
  cck_pkg::blk_t init;
  cck_pkg::blk_t ks_blk;
  logic          seq_busy;

  logic        s_accept;
  logic        need_block;
  logic        start;
  logic        push_now;
  logic        gen_done;
  logic        push;
  logic        pop;
  logic [7:0]  push_data;
  logic [6:0]  byte_idx;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_words_low   <= '0;
      key_words_mid   <= '0;
      key_words_upper <= '0;
      key_words_top   <= '0;
      nonce_first     <= '0;
      nonce_last      <= '0;
      start_counter   <= '0;
      mode            <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cck_pkg::REG_KEY_LOW:   key_words_low   <= cfg_data;
        cck_pkg::REG_KEY_MID:   key_words_mid   <= cfg_data;
        cck_pkg::REG_KEY_UPPER: key_words_upper <= cfg_data;
        cck_pkg::REG_KEY_TOP:   key_words_top   <= cfg_data;
        cck_pkg::REG_NONCE_LO:  nonce_first     <= cfg_data;
        cck_pkg::REG_NONCE_HI:  nonce_last      <= cfg_data[31:0];
        cck_pkg::REG_START_CTR: start_counter   <= cfg_data;
        cck_pkg::REG_MODE:      mode            <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // initial block words from key, constants and counter words
  always_comb begin
    init[0]  = cck_pkg::SIGMA0;
    init[1]  = mode[0] ? cck_pkg::SIGMA1_LNG : cck_pkg::SIGMA1_SHT;
    init[2]  = mode[0] ? cck_pkg::SIGMA2_LNG : cck_pkg::SIGMA2_SHT;
    init[3]  = cck_pkg::SIGMA3;
    init[4]  = key_words_low[31:0];
    init[5]  = key_words_low[63:32];
    init[6]  = key_words_mid[31:0];
    init[7]  = key_words_mid[63:32];
    init[8]  = mode[0] ? key_words_upper[31:0]  : key_words_low[31:0];
    init[9]  = mode[0] ? key_words_upper[63:32] : key_words_low[63:32];
    init[10] = mode[0] ? key_words_top[31:0]    : key_words_mid[31:0];
    init[11] = mode[0] ? key_words_top[63:32]   : key_words_mid[63:32];
    init[12] = counter_words[31:0];
    init[13] = counter_words[63:32];
    init[14] = counter_words[95:64];
    init[15] = counter_words[127:96];
  end

  cck_seq #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .ctl  (ctl),
    .busy (seq_busy)
  );

  cck_lanes u_lanes (
    .clk (clk),
    .ctl (ctl),
    .init(init),
    .blk (ks_blk)
  );

  // handshake decode
  assign s_tready   = !gen_pending && !skid_valid;
  assign s_accept   = s_tvalid && s_tready;
  assign need_block = (bytes_left == 7'd0) || (bytes_left > cck_pkg::BLK_BYTES);
  assign start      = s_accept && !s_tuser && need_block;
  assign push_now   = s_accept && !s_tuser && !need_block;
  assign gen_done   = ctl.last;
  assign pop        = m_tvalid && m_tready;

  // keystream byte select from the buffered block
  assign byte_idx  = cck_pkg::BLK_BYTES - bytes_left;
  assign ks_word   = ks_blk[byte_idx[5:2]];
  assign ks_byte   = 8'(ks_word >> {byte_idx[1:0], 3'b000});
  assign push      = push_now || gen_done;
  assign push_data = push_now ? (s_tdata ^ ks_byte) : (pend_data ^ ks_blk[0][7:0]);

  // counter words, byte count and pending block flag
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_words <= '0;
      bytes_left    <= '0;
      gen_pending   <= 1'b0;
    end else begin
      if (s_accept && s_tuser) begin
        if (mode[1]) begin
          counter_words <= {nonce_last, nonce_first, start_counter[31:0]};
        end else begin
          counter_words <= {nonce_first, start_counter};
        end
        bytes_left <= '0;
      end else if (start) begin
        gen_pending <= 1'b1;
      end else if (push_now) begin
        bytes_left <= bytes_left - 1'b1;
      end
      if (gen_done) begin
        counter_words <= counter_words + 128'd1;
        bytes_left    <= cck_pkg::BLK_BYTES - 7'd1;
        gen_pending   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pend_data <= s_tdata;
    end
  end

  // two-beat output queue
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!m_tvalid) begin
        m_tvalid <= 1'b1;
        m_tdata  <= push_data;
      end else if (pop) begin
        if (skid_valid) begin
          m_tdata   <= skid_data;
          skid_data <= push_data;
        end else begin
          m_tdata <= push_data;
        end
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end else if (pop) begin
      m_tvalid   <= skid_valid;
      m_tdata    <= skid_data;
      skid_valid <= 1'b0;
    end
  end

  `CCK_NEVER(a_skid_order, skid_valid && !m_tvalid)
  `CCK_NEVER(a_bytes_range, bytes_left > cck_pkg::BLK_BYTES)
  `CCK_IMPL(a_done_pending, gen_done, gen_pending && seq_busy)
  `CCK_NEXT(a_start_runs, start, seq_busy && gen_pending)

endmodule

`default_nettype wire
